/* src/bit_list_layout_rebalancer_assert.svh */
// assertion macros for the bit list layout rebalancer
`ifndef BIT_LIST_LAYOUT_REBALANCER_ASSERT_SVH
`define BIT_LIST_LAYOUT_REBALANCER_ASSERT_SVH
`ifndef SYNTHESIS
`define BLR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blr assertion failed");
`define BLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blr assertion failed");
`else
`define BLR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BLR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* src/blr_pkg.sv */
// types and constants shared by the bit list layout rebalancer
package blr_pkg;
    localparam int MAX_LISTS      = 256;
    localparam int DEPTH          = MAX_LISTS + 2;
    localparam int GUARD_BYTES    = 8;
    localparam int GUARD_LEN_BITS = GUARD_BYTES * 8;

    localparam logic [2:0] OP_CLEAR    = 3'd0;
    localparam logic [2:0] OP_WRITE    = 3'd1;
    localparam logic [2:0] OP_READ     = 3'd2;
    localparam logic [2:0] OP_EXTEND   = 3'd3;
    localparam logic [2:0] OP_VALIDATE = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_BAD      = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    localparam logic REG_MEMORY_BYTES = 1'b0;
    localparam logic REG_LIST_COUNT   = 1'b1;

    localparam logic [20:0] MEM_BYTES_RST  = 21'd65536;
    localparam logic [20:0] MEM_BYTES_MIN  = 21'd16;
    localparam logic [20:0] MEM_BYTES_MAX  = 21'd1048576;
    localparam logic [8:0]  LIST_COUNT_RST = 9'd256;
    localparam logic [8:0]  LIST_COUNT_MAX = 9'(MAX_LISTS);

    typedef struct packed {
        logic [2:0]  opcode;
        logic [8:0]  list_index;
        logic [23:0] start_bit;
        logic [15:0] size_bits;
        logic [8:0]  grow_index;
        logic [20:0] grow_bytes;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] start_out;
        logic [15:0] size_out;
        logic [20:0] gap_bytes;
    } result_t;

    typedef struct packed {
        logic [23:0] start;
        logic [15:0] size;
    } header_t;
endpackage

/* src/blr_hdr_mem.sv */
// header table memory with per-entry valid bits so unwritten entries read zero
module blr_hdr_mem (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [8:0]       wr_addr,
    input  blr_pkg::header_t wr_data,
    input  logic [8:0]       rd_addr,
    output blr_pkg::header_t rd_data
);
    import blr_pkg::*;

    header_t            mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    header_t            q_reg;
    logic               qv_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            qv_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            qv_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = qv_reg ? q_reg : '0;
endmodule

/* src/blr_div.sv */
// restoring divider, one quotient bit per cycle
module blr_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [23:0] dividend,
    input  logic [8:0]  divisor,
    output logic        done,
    output logic [23:0] quotient
);
    logic [8:0]  rem_reg, rem_next;
    logic [23:0] quo_reg, quo_next;
    logic [8:0]  dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [9:0]  trial;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[23]};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = 9'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[22:0], 1'b1};
            end
            else
            begin
                rem_next = trial[8:0];
                quo_next = {quo_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd23)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

/* src/bit_list_layout_rebalancer.sv */
// top level of the bit list layout rebalancer: sequencer, registers and result
//
// A command is taken when start is high and busy is low; busy then stays high
// until the single result beat, which sits on result for exactly one cycle
// with done high and must be captured then, since the receiver cannot stall.
// Write, out-of-range and unused-opcode commands keep busy high for 1 cycle,
// a header read for 3, and done comes in the first cycle after busy falls.
// Clear takes about 26 + (n + 2) cycles, extend about 2 * (n + 2) for
// the span sum, 26 for the gap division and 2 * (n + 2) for the re-placement,
// validate 2 * (n + 2), with n the effective list count: the header table has
// one read port with a registered output, and one 24-bit restoring divider
// gives one quotient bit per cycle. The header table needs no clearing pass
// after reset. Configuration writes are always taken (cfg_ready is high) and
// must only come while the block is idle.
`include "bit_list_layout_rebalancer_assert.svh"
module bit_list_layout_rebalancer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  blr_pkg::cmd_t    cmd,
    output logic             done,
    output blr_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [20:0]      cfg_data
);
    import blr_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_FETCH = 7'b0000100,
        S_USE   = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_CLEAR = 7'b0100000,
        S_CHECK = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;
    result_t     result_reg, result_next;
    logic        done_reg, done_next;
    logic [20:0] mem_bytes_reg;
    logic [8:0]  list_count_reg;
    logic [8:0]  n_reg, n_next;
    logic [20:0] bytes_reg, bytes_next;
    logic [8:0]  cnt_reg, cnt_next;
    logic [23:0] s_reg, s_next;
    logic [23:0] off_reg, off_next;
    logic [20:0] cur_reg, cur_next;
    logic [22:0] used_reg, used_next;
    logic [24:0] prev_end_reg, prev_end_next;
    logic        bad_reg, bad_next;
    logic        pass_reg, pass_next;   // extend: low while summing, high while placing

    // effective configuration
    logic [20:0] bytes_eff;
    logic [8:0]  n_eff;
    logic [23:0] bits;
    logic [8:0]  last_idx;

    // header table and divider hookup
    logic        wr_en;
    logic [8:0]  wr_addr;
    header_t     wr_data;
    header_t     rd_data;
    logic        div_start;
    logic [23:0] div_dividend;
    logic        div_done;
    logic [23:0] div_q;

    // per-entry arithmetic
    logic [13:0] span;
    logic [24:0] end_bit;
    logic [20:0] next_cur;

    always_comb
    begin
        if (mem_bytes_reg < MEM_BYTES_MIN)
            bytes_eff = MEM_BYTES_MIN;
        else if (mem_bytes_reg > MEM_BYTES_MAX)
            bytes_eff = MEM_BYTES_MAX;
        else
            bytes_eff = mem_bytes_reg;
        if (list_count_reg == 9'd0)
            n_eff = 9'd1;
        else if (list_count_reg > LIST_COUNT_MAX)
            n_eff = LIST_COUNT_MAX;
        else
            n_eff = list_count_reg;
    end

    assign bits     = {bytes_reg, 3'b000};
    assign last_idx = n_reg + 9'd1;

    // byte span and end bit of the header just read
    assign span    = 14'((17'(rd_data.start[2:0]) + 17'(rd_data.size) + 17'd7) >> 3);
    assign end_bit = 25'(rd_data.start) + 25'(rd_data.size);

    // running byte offset of the next list during placement
    always_comb
    begin
        next_cur = cur_reg + 21'(span) + s_reg[20:0];
        if (cnt_reg == 9'd0)
            next_cur = next_cur - 21'(s_reg[20:1]);
        if ((10'(cnt_reg) + 10'd1) == 10'(cmd_reg.grow_index))
            next_cur = next_cur + cmd_reg.grow_bytes;
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        result_next   = result_reg;
        done_next     = 1'b0;
        n_next        = n_reg;
        bytes_next    = bytes_reg;
        cnt_next      = cnt_reg;
        s_next        = s_reg;
        off_next      = off_reg;
        cur_next      = cur_reg;
        used_next     = used_reg;
        prev_end_next = prev_end_reg;
        bad_next      = bad_reg;
        pass_next     = pass_reg;
        wr_en         = 1'b0;
        wr_addr       = cnt_reg;
        wr_data       = '0;
        div_start     = 1'b0;
        div_dividend  = bits - 24'(GUARD_LEN_BITS);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    n_next     = n_eff;
                    bytes_next = bytes_eff;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                result_next = '0;
                cnt_next    = '0;
                unique case (cmd_reg.opcode) inside
                    OP_CLEAR:
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    OP_WRITE, OP_READ:
                    begin
                        if (cmd_reg.list_index > last_idx)
                        begin
                            result_next.status = ST_RANGE;
                            done_next          = 1'b1;
                            state_next         = S_IDLE;
                        end
                        else if (cmd_reg.opcode == OP_WRITE)
                        begin
                            wr_en        = 1'b1;
                            wr_addr      = cmd_reg.list_index;
                            wr_data      = '{start: cmd_reg.start_bit, size: cmd_reg.size_bits};
                            done_next    = 1'b1;
                            state_next   = S_IDLE;
                        end
                        else
                        begin
                            cnt_next   = cmd_reg.list_index;
                            state_next = S_FETCH;
                        end
                    end
                    OP_EXTEND:
                    begin
                        pass_next  = 1'b0;
                        used_next  = 23'(cmd_reg.grow_bytes);
                        state_next = S_FETCH;
                    end
                    OP_VALIDATE:
                    begin
                        bad_next   = 1'b0;
                        state_next = S_FETCH;
                    end
                    default:
                    begin
                        // unused opcode: all-zero result
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_FETCH:
            begin
                state_next = S_USE;
            end

            S_USE:
            begin
                state_next = S_FETCH;
                cnt_next   = cnt_reg + 9'd1;
                unique case (cmd_reg.opcode)
                    OP_READ:
                    begin
                        result_next.start_out = rd_data.start;
                        result_next.size_out  = rd_data.size;
                        done_next             = 1'b1;
                        state_next            = S_IDLE;
                    end
                    OP_EXTEND:
                    begin
                        if (!pass_reg)
                        begin
                            used_next = used_reg + 23'(span);
                            if (cnt_reg == last_idx)
                                state_next = S_CHECK;
                        end
                        else if (cnt_reg == last_idx)
                        begin
                            // tail guard sits flush against the end of the store
                            wr_en       = 1'b1;
                            wr_data     = '{start: bits - 24'(rd_data.size), size: rd_data.size};
                            result_next.gap_bytes = s_reg[20:0];
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            wr_en    = (cnt_reg != 9'd0);
                            wr_data  = '{start: {cur_reg, rd_data.start[2:0]},
                                         size: rd_data.size};
                            cur_next = next_cur;
                        end
                    end
                    default:
                    begin
                        // validate walk
                        prev_end_next = end_bit;
                        if (cnt_reg == 9'd0)
                        begin
                            if (rd_data.start != 24'd0)
                                bad_next = 1'b1;
                        end
                        else if (prev_end_reg > 25'(rd_data.start))
                        begin
                            bad_next = 1'b1;
                        end
                        if (cnt_reg == last_idx)
                        begin
                            if (bad_next || end_bit != 25'(bits)
                                || rd_data.size < 16'(GUARD_LEN_BITS))
                                result_next.status = ST_BAD;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end

            S_CHECK:
            begin
                if (23'(bytes_reg) < used_reg)
                begin
                    result_next.status = ST_OVERFLOW;
                    done_next          = 1'b1;
                    state_next         = S_IDLE;
                end
                else
                begin
                    div_dividend = 24'(bytes_reg - used_reg[20:0]);
                    div_start    = 1'b1;
                    state_next   = S_DIV;
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    s_next   = div_q;
                    off_next = {1'b0, div_q[23:1]};
                    cur_next = '0;
                    cnt_next = '0;
                    if (cmd_reg.opcode == OP_CLEAR)
                    begin
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        pass_next  = 1'b1;
                        state_next = S_FETCH;
                    end
                end
            end

            S_CLEAR:
            begin
                wr_en    = 1'b1;
                cnt_next = cnt_reg + 9'd1;
                if (cnt_reg == 9'd0)
                begin
                    wr_data = '0;
                end
                else if (cnt_reg == last_idx)
                begin
                    wr_data = '{start: bits - 24'(GUARD_LEN_BITS), size: 16'(GUARD_LEN_BITS)};
                    result_next.gap_bytes = 21'(s_reg >> 3);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    wr_data  = '{start: off_reg, size: 16'd0};
                    off_next = off_reg + s_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            done_reg       <= 1'b0;
            mem_bytes_reg  <= MEM_BYTES_RST;
            list_count_reg <= LIST_COUNT_RST;
            cnt_reg        <= '0;
            pass_reg       <= 1'b0;
            bad_reg        <= 1'b0;
            result_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
            pass_reg   <= pass_next;
            bad_reg    <= bad_next;
            result_reg <= result_next;
            if (cfg_valid)
            begin
                if (cfg_index == REG_MEMORY_BYTES)
                    mem_bytes_reg <= cfg_data;
                else
                    list_count_reg <= cfg_data[8:0];
            end
        end
    end

    // working registers of the current command
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        n_reg        <= n_next;
        bytes_reg    <= bytes_next;
        s_reg        <= s_next;
        off_reg      <= off_next;
        cur_reg      <= cur_next;
        used_reg     <= used_next;
        prev_end_reg <= prev_end_next;
    end

    blr_hdr_mem u_hdr_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (cnt_reg),
        .rd_data (rd_data)
    );

    blr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    // a result beat only ever appears once the sequencer is back at rest
    `BLR_ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy)
    // every accepted command leaves idle
    `BLR_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    // result strobe lasts one cycle
    `BLR_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    // an overflowing extend reports no gap
    `BLR_ASSERT_SAME(a_ovf_gap, clk, rst_n, done && result.status == ST_OVERFLOW,
        result.gap_bytes == 21'd0)
endmodule

/* bench/tb_top.sv */
// self-checking bench for the bit list layout rebalancer: random and directed commands
`timescale 1ns / 1ps
module tb_top;
    import blr_pkg::*;

    // first opcode with no function, the block answers with an all-zero beat
    localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
    localparam int         SETTLE_CYCLES   = 40;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    done;
    result_t result;
    logic    cfg_valid;
    logic    cfg_ready;
    logic    cfg_index;
    logic [20:0] cfg_data;

    bit_list_layout_rebalancer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the header table and the two registers
    logic [23:0] shadow_start [DEPTH];
    logic [15:0] shadow_size  [DEPTH];
    logic [20:0] mem_bytes_reg;
    logic [8:0]  list_count_reg;

    cmd_t    cmd_backlog[$];     // commands still to be offered
    result_t expected_beats[$];  // predicted results in order
    int      error_count;
    int      accepted_count;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic longint unsigned span_of(int k);
        return (longint'(shadow_start[k] & 24'd7) + shadow_size[k] + 7) / 8;
    endfunction

    // advances the shadow table by one command and returns the beat it should give
    function automatic result_t apply_command(cmd_t c);
        result_t r;
        longint unsigned n;
        longint unsigned bytes;
        longint unsigned bits;
        longint unsigned s;
        longint unsigned used;
        longint unsigned cur;
        longint unsigned nxt;
        longint unsigned tail_end;
        logic [23:0] placed [DEPTH];
        r = '0;
        n = (list_count_reg < 1) ? 1 : (list_count_reg > MAX_LISTS) ? MAX_LISTS : list_count_reg;
        bytes = (mem_bytes_reg < MEM_BYTES_MIN) ? MEM_BYTES_MIN :
                (mem_bytes_reg > MEM_BYTES_MAX) ? MEM_BYTES_MAX : mem_bytes_reg;
        bits = bytes * 8;
        case (c.opcode)
            OP_CLEAR:
            begin
                for (int i = 0; i <= n + 1; i++)
                begin
                    shadow_start[i] = '0;
                    shadow_size[i]  = '0;
                end
                shadow_start[n + 1] = 24'(bits - GUARD_LEN_BITS);
                shadow_size[n + 1]  = 16'(GUARD_LEN_BITS);
                s = (bits - GUARD_LEN_BITS) / n;
                for (int i = 1; i <= n; i++)
                    shadow_start[i] = 24'(s / 2 + (i - 1) * s);
                r.gap_bytes = 21'(s / 8);
            end
            OP_WRITE, OP_READ:
            begin
                if (c.list_index > n + 1)
                    r.status = ST_RANGE;
                else if (c.opcode == OP_WRITE)
                begin
                    shadow_start[c.list_index] = c.start_bit;
                    shadow_size[c.list_index]  = c.size_bits;
                end
                else
                begin
                    r.start_out = shadow_start[c.list_index];
                    r.size_out  = shadow_size[c.list_index];
                end
            end
            OP_EXTEND:
            begin
                used = c.grow_bytes;
                for (int i = 0; i <= n + 1; i++)
                    used += span_of(i);
                if (bytes < used)
                    r.status = ST_OVERFLOW;
                else
                begin
                    s = (bytes - used) / n;
                    cur = 0;
                    for (int i = 0; i <= n; i++)
                    begin
                        nxt = cur + span_of(i) + s;
                        if (i == 0)
                            nxt -= s / 2;
                        // grow space goes in front of the growing list
                        if (i + 1 == c.grow_index)
                            nxt += c.grow_bytes;
                        placed[i] = 24'(cur * 8 + (shadow_start[i] & 24'd7));
                        cur = nxt;
                    end
                    placed[n + 1] = 24'(bits - shadow_size[n + 1]);
                    for (int i = 1; i <= n + 1; i++)
                        shadow_start[i] = placed[i];
                    r.gap_bytes = 21'(s);
                end
            end
            OP_VALIDATE:
            begin
                tail_end = longint'(shadow_start[n + 1]) + shadow_size[n + 1];
                if (shadow_start[0] != 0 || tail_end != bits
                    || shadow_size[n + 1] < GUARD_LEN_BITS)
                    r.status = ST_BAD;
                else
                    for (int i = 0; i <= n; i++)
                        if (longint'(shadow_start[i]) + shadow_size[i] > shadow_start[i + 1])
                        begin
                            r.status = ST_BAD;
                            break;
                        end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // driver: predicts each accepted beat, then offers the next pending command
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_beats.push_back(apply_command(cmd));
                accepted_count++;
            end
            if (!start || !busy)
            begin
                // random idles, none in a long stretch of the run
                if ((accepted_count < 300 || accepted_count >= 420) &&
                    $urandom_range(0, 99) < 11)
                    start <= 1'b0;
                else if (cmd_backlog.size() > 0)
                begin
                    cmd   <= cmd_backlog.pop_front();
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: the result beat is there for one cycle only
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("result beat with nothing expected: %h", result);
                error_count++;
            end
            else
            begin
                result_t exp_r;
                exp_r = expected_beats.pop_front();
                if (result.status !== exp_r.status)
                begin
                    $error("status expected %0d got %0d", exp_r.status, result.status);
                    error_count++;
                end
                if (result.start_out !== exp_r.start_out)
                begin
                    $error("start_out expected %0d got %0d", exp_r.start_out, result.start_out);
                    error_count++;
                end
                if (result.size_out !== exp_r.size_out)
                begin
                    $error("size_out expected %0d got %0d", exp_r.size_out, result.size_out);
                    error_count++;
                end
                if (result.gap_bytes !== exp_r.gap_bytes)
                begin
                    $error("gap_bytes expected %0d got %0d", exp_r.gap_bytes, result.gap_bytes);
                    error_count++;
                end
            end
        end
    end

    function automatic int lists_now();
        return (list_count_reg < 1) ? 1 : (list_count_reg > MAX_LISTS) ? MAX_LISTS : list_count_reg;
    endfunction

    function automatic cmd_t make_cmd(logic [2:0] op, int idx, int gidx, int gsize);
        cmd_t c;
        c = '0;
        c.opcode     = op;
        c.list_index = 9'(idx);
        c.grow_index = 9'(gidx);
        c.grow_bytes = 21'(gsize);
        return c;
    endfunction

    // random command, mostly well formed for the current list count
    function automatic cmd_t random_cmd();
        cmd_t c;
        int   pick;
        int   n;
        n = lists_now();
        pick = $urandom_range(0, 99);
        c.opcode = (pick < 5)  ? OP_CLEAR :
                   (pick < 37) ? OP_WRITE :
                   (pick < 62) ? OP_READ :
                   (pick < 80) ? OP_EXTEND :
                   (pick < 96) ? OP_VALIDATE : 3'($urandom_range(OP_FIRST_UNUSED, 7));
        c.list_index  = ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(0, n + 1));
        c.start_bit   = ($urandom_range(0, 3) == 0) ? 24'($urandom) :
                        24'($urandom_range(0, mem_bytes_reg * 8));
        c.size_bits   = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
        c.grow_index  = ($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'($urandom_range(0, n + 1));
        c.grow_bytes  = ($urandom_range(0, 4) == 0) ? 21'($urandom) : 21'($urandom_range(0, 64));
        return c;
    endfunction

    // waits until everything offered has been answered and the block has gone quiet
    task automatic drain();
        do
            @(negedge clk);
        while (cmd_backlog.size() > 0 || start || busy || expected_beats.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic which, logic [20:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (which == REG_MEMORY_BYTES)
            mem_bytes_reg = value;
        else
            list_count_reg = value[8:0];
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        cmd_t c;
        int   n;
        logic [20:0] phase_bytes [7] = '{21'd16, 21'd1048576, 21'd0, 21'h1FFFFF,
                                          21'd100, 21'd4096, 21'h0AAAAA};
        logic [8:0]  phase_lists [7] = '{9'd1, 9'd256, 9'd0, 9'h1FF, 9'd3, 9'd8, 9'd5};
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MEMORY_BYTES;
        cfg_data = '0;
        error_count = 0;
        accepted_count = 0;
        mem_bytes_reg = MEM_BYTES_RST;
        list_count_reg = LIST_COUNT_RST;
        for (int i = 0; i < DEPTH; i++)
        begin
            shadow_start[i] = '0;
            shadow_size[i] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at reset configuration: a read and a validate of the zeroed table first
        n = lists_now();
        cmd_backlog.push_back(make_cmd(OP_READ, n + 1, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_VALIDATE, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_CLEAR, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_READ, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_READ, n + 1, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_VALIDATE, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_EXTEND, 0, 1, 0));
        cmd_backlog.push_back(make_cmd(OP_EXTEND, 0, n + 1, 100));
        // grow index outside the lists still counts in the sum
        cmd_backlog.push_back(make_cmd(OP_EXTEND, 0, 0, 50));
        cmd_backlog.push_back(make_cmd(OP_EXTEND, 0, 511, 50));
        cmd_backlog.push_back(make_cmd(OP_EXTEND, 0, 3, 21'h1FFFFF));
        cmd_backlog.push_back(make_cmd(OP_VALIDATE, 0, 0, 0));
        // out-of-range index on write and read
        c = make_cmd(OP_WRITE, 511, 0, 0);
        c.start_bit = 24'hFFFFFF;
        c.size_bits = 16'hFFFF;
        cmd_backlog.push_back(c);
        cmd_backlog.push_back(make_cmd(OP_READ, 511, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_READ, n + 2, 0, 0));
        // overlapping list breaks validate, then extreme header values
        c.list_index = 9'd1;
        cmd_backlog.push_back(c);
        cmd_backlog.push_back(make_cmd(OP_READ, 1, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_VALIDATE, 0, 0, 0));
        c.list_index = 9'd0;
        c.start_bit = 24'd1;
        c.size_bits = 16'd0;
        cmd_backlog.push_back(c);
        cmd_backlog.push_back(make_cmd(OP_VALIDATE, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_EXTEND, 0, 1, 0));
        for (int k = OP_FIRST_UNUSED; k <= 7; k++)
            cmd_backlog.push_back(make_cmd(3'(k), 0, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_CLEAR, 0, 0, 0));
        drain();

        // random phases, each under its own register setting
        for (int p = 0; p <= 7; p++)
        begin
            if (p > 0)
            begin
                write_reg(REG_MEMORY_BYTES, phase_bytes[p - 1]);
                write_reg(REG_LIST_COUNT, 21'(phase_lists[p - 1]));
            end
            cmd_backlog.push_back(make_cmd(OP_CLEAR, 0, 0, 0));
            // sender fully paused at the end of every phase via drain
            for (int k = 0; k < 88; k++)
                cmd_backlog.push_back(random_cmd());
            drain();
        end

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
